@@ hdl/uitp_pkg.sv @@
// ----------------------------------------------------------------------------
// uitp_pkg: shared types and constants of the unsigned integer text parser
// Beat structs for both channels, the parse phase encoding and the character
// and radix constants.
// ----------------------------------------------------------------------------
package uitp_pkg;

  localparam int unsigned BASE_W           = 6;
  localparam int unsigned OFFSET_BITS_DEF  = 16;
  localparam int unsigned VALUE_W          = 64;
  localparam int unsigned END_OFFSET_W     = 16;

  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_F  = 8'h46;
  localparam logic [7:0] CH_LOWER_X  = 8'h78;
  localparam logic [7:0] CASE_BIT    = 8'h20;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_DIGITS    = 5'b00010,
    PH_ZERO_AUTO = 5'b00100,
    PH_ZERO_HEX  = 5'b01000,
    PH_X_AUTO    = 5'b10000
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       string_start;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_W-1:0]      parsed_value;
    logic [END_OFFSET_W-1:0] end_offset;
  } out_beat_t;

endpackage

@@ hdl/unsigned_integer_text_parser.sv @@
// ----------------------------------------------------------------------------
// unsigned_integer_text_parser: streaming unsigned integer parser
// Parses one character per beat into a 64-bit value, with auto radix detect.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | sink      | in_valid_i/in_stall_o | char_byte, string_start
//  out     | source    | out_valid_o/out_stall_i | parsed_value, end_offset
//  cfg     | sink      | cfg_we_i              | number_base (6 bits)
//
// One character per cycle sustained while the input is not stalled. A beat is
// first held in the input register; as it moves on, the multiply-add updates
// the accumulator and, when the beat ends the string, the result register is
// loaded, where the result waits until the output takes it.
// The rate is set by the accumulator loop: one 64x6 multiply plus digit add
// per cycle.
// Reset (rst_ni low, async) empties both registers and parks the parser idle.
// An input stall only arises while a result waits on a stalled output and the
// beat in the input register would stop the parse; other beats flow on.
// number_base is sampled at each string start.

module unsigned_integer_text_parser #(
  parameter int unsigned OFFSET_BITS = uitp_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  uitp_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output uitp_pkg::out_beat_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [uitp_pkg::BASE_W-1:0]   cfg_wdata_i
);

  import uitp_pkg::*;

  localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

  // Registers
  logic                   in_valid_q;
  in_beat_t               in_q;
  logic [BASE_W-1:0]      cfg_base_q;
  parse_phase_e           ph_q, ph_d;
  logic [BASE_W-1:0]      base_q, base_d;
  logic [VALUE_W-1:0]     acc_q, acc_d;
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
  logic                   out_valid_q;
  out_beat_t              out_q;

  // Datapath
  logic [7:0]             ch;
  logic                   start;
  logic                   is_hex, is_x, take, stop;
  logic [3:0]             dig;
  logic [7:0]             dig_wide;
  logic [BASE_W-1:0]      base_w;
  logic [VALUE_W-1:0]     acc_w;
  logic [OFFSET_BITS-1:0] cnt_w;
  logic                   slot_free, fire;
  logic [31:0]            cnt_ext;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign ch    = in_q.char_byte;
  assign start = in_q.string_start;

  // Character classes
  always_comb begin
    is_hex   = (ch inside {[CH_ZERO:CH_NINE], [CH_LOWER_A:CH_LOWER_F],
                           [CH_UPPER_A:CH_UPPER_F]});
    is_x     = ((ch | CASE_BIT) == CH_LOWER_X);
    dig_wide = (ch inside {[CH_ZERO:CH_NINE]}) ? (ch - CH_ZERO)
                                               : ((ch | CASE_BIT) - CH_LOWER_A + 8'd10);
    dig      = dig_wide[3:0];
  end

  // Parse step: pick the working base/value/count, then take a digit, move
  // through the 0/0x prefix, or stop and hand out a result.
  always_comb begin
    base_w = base_q;
    acc_w  = acc_q;
    cnt_w  = cnt_q;
    ph_d   = ph_q;
    take   = 1'b0;
    stop   = 1'b0;

    if (start) begin
      acc_w  = '0;
      cnt_w  = '0;
      base_w = (cfg_base_q == BASE_AUTO) ? BASE_DEC : cfg_base_q;
      if (cfg_base_q == BASE_AUTO && ch == CH_ZERO) begin
        base_w = BASE_OCT;
        cnt_w  = sat_inc('0);
        ph_d   = PH_ZERO_AUTO;
      end else if (cfg_base_q == BASE_HEX && ch == CH_ZERO) begin
        cnt_w  = sat_inc('0);
        ph_d   = PH_ZERO_HEX;
      end else begin
        take   = 1'b1;
      end
    end else begin
      case (ph_q)
        PH_DIGITS: take = 1'b1;
        PH_ZERO_AUTO: begin
          if (is_x) ph_d = PH_X_AUTO;
          else      take = 1'b1;
        end
        PH_ZERO_HEX: begin
          if (is_x) begin
            cnt_w = sat_inc(cnt_q);
            ph_d  = PH_DIGITS;
          end else begin
            take  = 1'b1;
          end
        end
        PH_X_AUTO: begin
          // "0x" plus a hex digit: the x counts, then the digit goes in.
          if (is_hex) begin
            base_w = BASE_HEX;
            cnt_w  = sat_inc(cnt_q);
            take   = 1'b1;
          end else begin
            stop   = 1'b1;
          end
        end
        default: ;
      endcase
    end

    acc_d  = acc_w;
    cnt_d  = cnt_w;
    base_d = base_w;
    if (take) begin
      if (is_hex && (BASE_W'(dig) < base_w)) begin
        acc_d = acc_w * VALUE_W'(base_w) + VALUE_W'(dig);
        cnt_d = sat_inc(cnt_w);
        ph_d  = PH_DIGITS;
      end else begin
        stop  = 1'b1;
      end
    end
    if (stop) ph_d = PH_IDLE;
  end

  // Handshake: the beat in the input register moves on unless it would stop
  // the parse while the result register is still held.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && (!stop || slot_free);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q <= BASE_AUTO;
    end else if (cfg_we_i) begin
      cfg_base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
    end else if (fire) begin
      ph_q <= ph_d;
    end
  end

  // Parse datapath; every string start reloads it.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      base_q <= base_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

  assign cnt_ext = 32'(cnt_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && stop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && stop) begin
      out_q.parsed_value <= acc_w;
      out_q.end_offset   <= cnt_ext[END_OFFSET_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/uitp_checker.sv @@
// ----------------------------------------------------------------------------
// uitp_checker: port-level checks of the unsigned integer text parser
// Watches the top level's ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module uitp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input uitp_pkg::in_beat_t           in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input uitp_pkg::out_beat_t          out_data_o,
  input logic                         cfg_we_i,
  input logic [uitp_pkg::BASE_W-1:0]  cfg_wdata_i
);

  import uitp_pkg::*;

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Input back-pressure only comes from a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A fresh result traces back to a beat taken at the input port.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching input beat");

endmodule

bind unsigned_integer_text_parser uitp_checker u_uitp_checker (.*);

@@ verif/uitp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uitp_scoreboard: result predictor and scoreboard for the text parser
// Watches the input, output and register ports. It mirrors the radix and the
// parse state, queues the result each string should give and compares every
// result beat against the oldest one waiting.
// ----------------------------------------------------------------------------
module uitp_scoreboard #(
  parameter int unsigned OFFSET_BITS = uitp_pkg::OFFSET_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  uitp_pkg::in_beat_t          in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  uitp_pkg::out_beat_t         out_data_i,
  input  logic                        cfg_we_i,
  input  logic [uitp_pkg::BASE_W-1:0] cfg_wdata_i,
  output int unsigned                 fail_cnt_o,
  output int unsigned                 pending_o,
  output int unsigned                 results_o
);
  import uitp_pkg::*;

  localparam logic [63:0] COUNT_MAX = (64'd1 << OFFSET_BITS) - 64'd1;

  logic [BASE_W-1:0]  radix_reg;     // mirror of number_base
  logic [BASE_W-1:0]  string_radix;  // radix in force for the current string
  parse_phase_e       phase;
  logic [VALUE_W-1:0] value_acc;
  logic [63:0]        char_cnt;
  out_beat_t          parse_results_q[$];

  function automatic bit is_hex_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO && ch <= CH_NINE) ||
           (ch >= CH_LOWER_A && ch <= CH_LOWER_F) ||
           (ch >= CH_UPPER_A && ch <= CH_UPPER_F);
  endfunction

  function automatic logic [4:0] digit_value(input logic [7:0] ch);
    logic [7:0] lower;
    lower = ch | CASE_BIT;
    if (ch <= CH_NINE) return 5'(ch - CH_ZERO);
    return 5'(lower - CH_LOWER_A + 8'd10);
  endfunction

  function automatic bit is_x(input logic [7:0] ch);
    return (ch | CASE_BIT) == CH_LOWER_X;
  endfunction

  task automatic count_char();
    if (char_cnt < COUNT_MAX) char_cnt++;
  endtask

  task automatic close_string();
    out_beat_t r;
    r.parsed_value = value_acc;
    r.end_offset   = END_OFFSET_W'(char_cnt & COUNT_MAX);
    parse_results_q.push_back(r);
    phase = PH_IDLE;
  endtask

  task automatic take_digit(input logic [7:0] ch);
    if (is_hex_digit(ch) && digit_value(ch) < string_radix) begin
      value_acc = value_acc * string_radix + digit_value(ch);
      count_char();
      phase = PH_DIGITS;
    end else begin
      close_string();
    end
  endtask

  task automatic parse_char(input in_beat_t b);
    if (b.string_start) begin
      value_acc    = '0;
      char_cnt     = '0;
      string_radix = radix_reg;
      if (string_radix == BASE_AUTO && b.char_byte == CH_ZERO) begin
        string_radix = BASE_OCT;
        count_char();
        phase = PH_ZERO_AUTO;
      end else if (string_radix == BASE_HEX && b.char_byte == CH_ZERO) begin
        count_char();
        phase = PH_ZERO_HEX;
      end else begin
        if (string_radix == BASE_AUTO) string_radix = BASE_DEC;
        take_digit(b.char_byte);
      end
    end else begin
      case (phase)
        PH_DIGITS: take_digit(b.char_byte);
        PH_ZERO_AUTO: begin
          // the x itself is only counted once a hex digit follows
          if (is_x(b.char_byte)) phase = PH_X_AUTO;
          else take_digit(b.char_byte);
        end
        PH_ZERO_HEX: begin
          if (is_x(b.char_byte)) begin
            count_char();
            phase = PH_DIGITS;
          end else begin
            take_digit(b.char_byte);
          end
        end
        PH_X_AUTO: begin
          if (is_hex_digit(b.char_byte)) begin
            string_radix = BASE_HEX;
            count_char();
            take_digit(b.char_byte);
          end else begin
            close_string();
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      radix_reg    = BASE_AUTO;
      string_radix = BASE_AUTO;
      phase        = PH_IDLE;
      value_acc    = '0;
      char_cnt     = '0;
      parse_results_q.delete();
      fail_cnt_o   = 0;
      results_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (parse_results_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: unexpected result value=%h offset=%0d", $realtime,
                     out_data_i.parsed_value, out_data_i.end_offset);
        end else begin
          want = parse_results_q.pop_front();
          if (want.parsed_value !== out_data_i.parsed_value ||
              want.end_offset !== out_data_i.end_offset) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display("%0t: mismatch value exp=%h got=%h, offset exp=%0d got=%0d",
                       $realtime, want.parsed_value, out_data_i.parsed_value,
                       want.end_offset, out_data_i.end_offset);
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_char(in_data_i);
      if (cfg_we_i) radix_reg = cfg_wdata_i;
    end
    pending_o = parse_results_q.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for unsigned_integer_text_parser
// Feeds strings one character per beat under a series of radix settings:
// a directed set of corner strings, a back-pressure burst, and random strings
// with prefixes, restarts and noise. Checking is done by uitp_scoreboard
// beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import uitp_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 4;     // result passes the input and result registers
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any beat moving
  localparam int PHASE_BEATS    = 42;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  in_beat_t          in_data   = '0;
  logic              in_stall;
  logic              out_valid;
  out_beat_t         out_data;
  logic              out_stall = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [BASE_W-1:0] cfg_wdata = '0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned results;

  // stimulus bookkeeping
  bit          head        = 1'b0;  // next character opens a string
  bit          gaps_on     = 1'b1;  // sender idles between bursts
  bit          hold_req    = 1'b0;  // ask the receiver for a long hold-off
  int          burst_left  = 0;
  int unsigned string_beats = 0;
  int unsigned radix_writes = 0;
  int          idle_cycles  = 0;

  logic [BASE_W-1:0] radix_plan [9] = '{BASE_DEC, BASE_OCT, 6'd2, BASE_HEX,
                                        BASE_AUTO, 6'd36, 6'd1, 6'd7, BASE_AUTO};

  unsigned_integer_text_parser uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  uitp_scoreboard u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .results_o   (results)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: stall pattern picked per stretch (none, light random, periodic,
  // heavy random). A hold request overrides it for HOLD_CYCLES.
  initial begin
    int mode, span, tick, hold_left;
    hold_left = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (tick = 0; tick < span; tick++) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req  = 1'b0;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          out_stall <= 1'b1;
          hold_left--;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= (tick % 3 == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Offer one beat and hold it until taken. Called at a falling edge and
  // returns at one; valid is only dropped when a burst ends.
  task automatic send_beat(input logic [7:0] ch, input logic st);
    in_valid <= 1'b1;
    in_data  <= '{char_byte: ch, string_start: st};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_beat(ch, head);
    head = 1'b0;
    string_beats++;
  endtask

  task automatic put_text(input string s);
    head = 1'b1;
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return CH_ZERO + 8'(d);
    if ($urandom_range(0, 1)) return CH_UPPER_A + 8'(d - 10);
    return CH_LOWER_A + 8'(d - 10);
  endfunction

  function automatic logic [7:0] x_char();
    return $urandom_range(0, 1) ? CH_LOWER_X : (CH_LOWER_X & ~CASE_BIT);
  endfunction

  // Stop sending and wait until every queued result has come out, then the
  // settle time for a beat that gives no result.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_radix(input logic [BASE_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we    <= 1'b0;
    radix_writes++;
  endtask

  // One random string for radix r. Mostly well-formed: optional prefix,
  // valid digits, then a random stop byte. Some strings are cut short by the
  // next start, some are followed by junk, and some beats are pure noise.
  task automatic send_random_string(input logic [BASE_W-1:0] r);
    int n, lim, k;
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 5);
      for (k = 0; k < n; k++)
        send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      head = 1'b1;
      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      lim = (r > BASE_HEX) ? 16 : int'(r);
      if (r == BASE_AUTO) begin
        case ($urandom_range(0, 2))
          0: begin
            lim = 10;
            if (n > 0) begin
              put_char(digit_char($urandom_range(1, 9)));
              n--;
            end
          end
          1: begin
            lim = 8;
            put_char(CH_ZERO);
          end
          default: begin
            lim = 16;
            put_char(CH_ZERO);
            put_char(x_char());
          end
        endcase
      end else if (r == BASE_HEX && $urandom_range(0, 1)) begin
        put_char(CH_ZERO);
        put_char(x_char());
      end
      for (k = 0; k < n; k++) put_char(digit_char($urandom_range(0, lim - 1)));
      // no stop byte now and then: the next start abandons the string
      if ($urandom_range(0, 9) != 0)
        put_char($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_beat(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  initial begin
    int p;
    logic [BASE_W-1:0] r;
    int unsigned goal;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners, radix still at its auto reset value.
    send_beat(8'h71, 1'b0);                  // stray char while idle: dropped
    put_text("0x1F"); put_char(8'h00);        // auto hex prefix
    put_text("0xg");                          // 0x without hex digit: only the 0
    put_text("08");                           // octal stops at 8
    put_text("12"); put_text("5");            // restart drops the 12
    put_char(8'h00);
    head = 1'b1; put_char(8'h00);             // empty string
    drain_all();
    set_radix(BASE_HEX);
    put_text("0Xz");                          // hex prefix then non-digit
    put_text("Ab"); put_char(8'hFF);
    drain_all();
    set_radix(6'd36);
    put_text("fG");                           // above 16 only hex letters count
    drain_all();
    set_radix(6'd1);
    put_text("01");                           // radix 1 takes only 0
    drain_all();

    // Back-pressure: receiver holds off while short strings stream in
    // back to back, so results pile up and the input stalls.
    set_radix(BASE_DEC);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (30) begin
      head = 1'b1;
      put_char(digit_char($urandom_range(0, 9)));
      put_char(8'h2C);
    end
    gaps_on = 1'b1;
    drain_all();

    // Random strings, one phase per radix; every third phase runs gap-free.
    for (p = 0; p < 9; p++) begin
      r = (p == 8) ? BASE_W'($urandom_range(2, 36)) : radix_plan[p];
      set_radix(r);
      gaps_on = (p % 3 != 2);
      goal    = string_beats + PHASE_BEATS;
      while (string_beats < goal) send_random_string(r);
      drain_all();
    end

    $display("Sent %0d string beats under %0d radix writes, %0d results compared.",
             string_beats, radix_writes, results);
    $display("Covered prefixes, restarts, stalls, noise and a spread of radix values.");
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ unsigned_integer_text_parser.f @@
hdl/uitp_pkg.sv
hdl/unsigned_integer_text_parser.sv
hdl/uitp_checker.sv
verif/uitp_checker.sv
verif/testbench.sv
